// ----- hw/rtl/pcmlr_pkg.sv -----
package pcmlr_pkg;

	typedef logic signed [15:0] sample_t;

	localparam int SampleW    = 16;
	localparam int LengthW    = 16;
	localparam int StepW      = 21;
	localparam int PerKindMax = 16;
	localparam int KindCntW   = 5;
	localparam int CfgIndexW  = 1;

	localparam logic [StepW-1:0]     StepReset      = 21'd65536;
	localparam logic [CfgIndexW-1:0] RegPhaseStep   = 1'd0;
	localparam logic [CfgIndexW-1:0] RegByteSamples = 1'd1;

	function automatic sample_t normalize(input logic [SampleW-1:0] raw, input logic byte_mode);
		sample_t res;
		if (byte_mode) begin
			res = sample_t'({~raw[7], raw[6:0], 8'h00});
		end else begin
			res = sample_t'(raw);
		end
		return res;
	endfunction

endpackage

// ----- hw/rtl/pcm_linear_resampler_top.sv -----
// Linear interpolation sample rate converter for mono PCM audio.
// Input words arrive on s_tvalid/s_tready/s_tdata, one sample per word together
// with the length of the block that the sample belongs to. Result words leave on
// m_tvalid/m_tready/m_tdata, with m_tlast high on the final result of a block.
// Configuration words on cfg_valid/cfg_ready/cfg_index/cfg_data set the phase step
// (index 0, unsigned fixed point with FRACTION_BITS fraction bits) and the sample
// format (index 1, 0 for 16-bit signed and 1 for 8-bit offset binary). They are to be
// written only while the block is idle; the block does not enforce this and cfg_ready
// is always high. One input word produces up to 32 result words, and every result
// goes twice through the single position adder and compare unit. The block takes
// no input word while one is being worked on. After an input word is accepted, the
// first result is prepared in S_INT and S_MUL (or S_REP and S_REPE) and registered.
// A finished result waits in the output register while the next one is prepared,
// so a stalled receiver holds the sequencer only once that register is full.
// Reset clears the sample history, the position and the input count, and loads
// the default step of one input per output and 16-bit samples.
module pcm_linear_resampler_top
	import pcmlr_pkg::*;
#(
	parameter int FRACTION_BITS = 16
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_tvalid,
	output logic                 s_tready,
	input  logic [31:0]          s_tdata,   // raw_sample [15:0], block_length [31:16]
	output logic                 m_tvalid,
	input  logic                 m_tready,
	output logic [15:0]          m_tdata,   // sample_out [15:0]
	output logic                 m_tlast,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CfgIndexW-1:0] cfg_index,
	input  logic [StepW-1:0]     cfg_data
);

	localparam int FB     = FRACTION_BITS;
	localparam int PosW   = (FB + 17 > 34) ? FB + 17 : 34;
	localparam int SumW   = PosW + 1;
	localparam int IntW   = PosW - FB;
	localparam int ProdW  = FB + 18;
	localparam logic [StepW-1:0] StepMin = StepW'(1) << (FB - 4);
	localparam logic [PosW-1:0]  PosKeep = PosW'({34{1'b1}});

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_INT  = 3'd1;
	localparam logic [2:0] S_MUL  = 3'd2;
	localparam logic [2:0] S_REP  = 3'd3;
	localparam logic [2:0] S_REPE = 3'd4;
	localparam logic [2:0] S_DONE = 3'd5;

	logic [2:0]          state_q;
	logic [StepW-1:0]    phase_step_q;
	logic                byte_samples_q;
	sample_t             prev_q;
	sample_t             cur_q;
	logic [LengthW-1:0]  len_q;
	logic [LengthW-1:0]  count_q;
	logic                last_q;
	logic [KindCntW-1:0] k_q;
	logic [PosW-1:0]     pos_q;
	logic signed [ProdW-1:0] prod_s1;
	logic [15:0]         out_data_q;
	logic                out_last_q;
	logic                out_valid_q;

	logic [StepW-1:0]    step_eff;
	logic [SumW-1:0]     pos_sum;
	logic [SumW-1:0]     limit;
	logic                fits;
	logic                behind;
	logic                out_free;
	logic                out_load;
	logic [LengthW-1:0]  in_len;
	logic [LengthW-1:0]  in_len_eff;
	logic signed [16:0]  diff;
	logic signed [FB:0]  frac_s;
	logic signed [ProdW-1:0] prod_w;
	logic signed [ProdW-1:0] shifted;
	logic signed [17:0]  interp;
	logic                k_open;

	assign s_tready  = (state_q == S_IDLE);
	assign cfg_ready = 1'b1;
	assign m_tvalid  = out_valid_q;
	assign m_tdata   = out_data_q;
	assign m_tlast   = out_last_q;

	assign in_len     = s_tdata[31:16];
	assign in_len_eff = (in_len == '0) ? LengthW'(1) : in_len;
	assign step_eff   = (phase_step_q < StepMin) ? StepMin : phase_step_q;
	assign pos_sum    = {1'b0, pos_q} + SumW'(step_eff);
	assign limit      = SumW'({len_q, {FB{1'b0}}});
	assign fits       = (pos_sum <= limit);
	assign behind     = (pos_q[PosW-1:FB] < IntW'(count_q));
	assign out_free   = !out_valid_q || m_tready;
	assign out_load   = ((state_q == S_MUL) || (state_q == S_REPE)) && out_free;
	assign k_open     = (k_q < KindCntW'(PerKindMax));

	assign diff    = {cur_q[15], cur_q} - {prev_q[15], prev_q};
	assign frac_s  = $signed({1'b0, pos_q[FB-1:0]});
	assign prod_w  = ProdW'(frac_s) * ProdW'(diff);
	assign shifted = prod_s1 >>> FB;
	assign interp  = {{2{prev_q[15]}}, prev_q} + shifted[17:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_step_q   <= StepReset;
			byte_samples_q <= 1'b0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				RegPhaseStep:   phase_step_q   <= cfg_data;
				RegByteSamples: byte_samples_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			prev_q      <= '0;
			count_q     <= '0;
			pos_q       <= '0;
			k_q         <= '0;
			last_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (s_tvalid) begin
						cur_q  <= normalize(s_tdata[15:0], byte_samples_q);
						len_q  <= in_len_eff;
						last_q <= (count_q >= in_len_eff - LengthW'(1));
						k_q    <= '0;
						if (count_q != '0) begin
							state_q <= S_INT;
						end else if (count_q >= in_len_eff - LengthW'(1)) begin
							state_q <= S_REP;
						end else begin
							state_q <= S_DONE;
						end
					end
				end
				S_INT: begin
					if (k_open && behind && fits) begin
						prod_s1 <= prod_w;
						pos_q   <= pos_sum[PosW-1:0];
						k_q     <= k_q + KindCntW'(1);
						state_q <= S_MUL;
					end else begin
						k_q     <= '0;
						state_q <= last_q ? S_REP : S_DONE;
					end
				end
				S_MUL: begin
					if (out_free) begin
						out_data_q  <= interp[15:0];
						out_last_q  <= last_q && !fits;
						state_q     <= S_INT;
					end
				end
				S_REP: begin
					if (k_open && fits) begin
						pos_q   <= pos_sum[PosW-1:0];
						k_q     <= k_q + KindCntW'(1);
						state_q <= S_REPE;
					end else begin
						state_q <= S_DONE;
					end
				end
				S_REPE: begin
					if (out_free) begin
						out_data_q  <= cur_q;
						out_last_q  <= !fits || !k_open;
						state_q     <= S_REP;
					end
				end
				S_DONE: begin
					if (last_q) begin
						count_q <= '0;
						pos_q   <= '0;
					end else begin
						count_q <= count_q + LengthW'(1);
						pos_q   <= pos_q & PosKeep;
					end
					prev_q  <= cur_q;
					state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("input accepted while the previous word was still in progress");

	a_kind_bound: assert property (@(posedge clk) disable iff (!arst_n)
		k_q <= KindCntW'(PerKindMax))
		else $error("more than the allowed number of results of one kind");

	a_block_restart: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DONE) && last_q |=> (pos_q == '0) && (count_q == '0))
		else $error("position or count not cleared at the end of a block");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		((state_q == S_MUL) || (state_q == S_REPE)) && !out_free |=>
		$stable(out_data_q) && (state_q == $past(state_q)))
		else $error("pending result overwritten while the receiver stalls");

endmodule

// ----- tb/tb_top.sv -----
`timescale 1ns / 1ps

module tb_top;
	import pcmlr_pkg::*;

	localparam int FracBits = 16;
	localparam longint unsigned MinStep = 64'd1 << (FracBits - 4);
	localparam longint unsigned FracMask = (64'd1 << FracBits) - 1;
	localparam longint unsigned PosMask = (64'd1 << 34) - 1;
	localparam int HoldCycles = 400;
	localparam int SettleCycles = 100;
	localparam int StallLimit = 4000;
	localparam int PhaseItems = 6;

	typedef enum logic [1:0] {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} idle_mode_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [31:0] s_tdata = '0;
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [15:0] m_tdata;
	logic m_tlast;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [CfgIndexW-1:0] cfg_index = '0;
	logic [StepW-1:0] cfg_data = '0;

	logic [31:0] pending_words[$];
	sample_t expected_samples[$];
	bit expected_marks[$];

	logic [StepW-1:0] step_reg = StepReset;
	logic byte_mode = 1'b0;
	int prev_sample = 0;
	logic [15:0] in_count = '0;
	longint unsigned out_pos = 0;

	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	int hold_requests = 0;
	int holds_done = 0;
	int hold_left = 0;
	int err_count = 0;
	int quiet_cycles = 0;

	pcm_linear_resampler_top #(
		.FRACTION_BITS(FracBits)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tlast(m_tlast),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always #4 clk = ~clk;

	task automatic resample_word(input logic [15:0] raw, input logic [15:0] blen);
		int cur;
		int made;
		longint unsigned eff_step;
		longint unsigned len;
		longint unsigned limit;
		longint unsigned n;
		longint prod;
		bit is_final;
		cur = byte_mode ? (int'(raw[7:0]) - 128) * 256 : int'($signed(raw));
		eff_step = (longint'(step_reg) < MinStep) ? MinStep : longint'(step_reg);
		len = (blen == 16'd0) ? 1 : blen;
		limit = len << FracBits;
		n = in_count;
		is_final = (n >= len - 1);
		made = 0;
		if (n > 0) begin
			for (int k = 0; k < PerKindMax; k++) begin
				if ((out_pos >> FracBits) >= n || out_pos + eff_step > limit)
					break;
				prod = longint'(out_pos & FracMask) * longint'(cur - prev_sample);
				expected_samples.push_back(sample_t'(prev_sample + int'(prod >>> FracBits)));
				expected_marks.push_back(1'b0);
				made++;
				out_pos += eff_step;
			end
		end
		if (is_final) begin
			for (int k = 0; k < PerKindMax; k++) begin
				if (out_pos + eff_step > limit)
					break;
				expected_samples.push_back(sample_t'(cur));
				expected_marks.push_back(1'b0);
				made++;
				out_pos += eff_step;
			end
			if (made > 0) begin
				void'(expected_marks.pop_back());
				expected_marks.push_back(1'b1);
			end
			in_count = '0;
			out_pos = 0;
		end else begin
			in_count = in_count + 16'd1;
			out_pos = out_pos & PosMask;
		end
		prev_sample = cur;
	endtask

	always @(posedge clk) begin
		if (s_tvalid && s_tready)
			resample_word(s_tdata[15:0], s_tdata[31:16]);
		if (!s_tvalid || s_tready) begin
			if (pending_words.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
				s_tvalid <= 1'b1;
				s_tdata <= pending_words.pop_front();
			end else begin
				s_tvalid <= 1'b0;
			end
		end
	end

	always @(posedge clk) begin
		sample_t exp_value;
		bit exp_mark;
		if (m_tvalid && m_tready) begin
			if (expected_samples.size() == 0) begin
				$display("%0t: unexpected word, expected none, got sample %0d last %0b",
					$time, $signed(m_tdata), m_tlast);
				err_count++;
			end else begin
				exp_value = expected_samples.pop_front();
				exp_mark = expected_marks.pop_front();
				if (m_tdata !== 16'(exp_value)) begin
					$display("%0t: sample mismatch, expected %0d, got %0d",
						$time, exp_value, $signed(m_tdata));
					err_count++;
				end
				if (m_tlast !== exp_mark) begin
					$display("%0t: last flag mismatch, expected %0b, got %0b",
						$time, exp_mark, m_tlast);
					err_count++;
				end
			end
		end
		if (holds_done != hold_requests) begin
			hold_left = HoldCycles;
			holds_done++;
		end
		if (hold_left > 0) begin
			hold_left--;
			m_tready <= 1'b0;
		end else begin
			m_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
		end
	end

	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= StallLimit) begin
			$display("%0t: no progress for %0d cycles, %0d results outstanding",
				$time, quiet_cycles, expected_samples.size());
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	task automatic push_word(input logic [15:0] raw, input logic [15:0] blen);
		pending_words.push_back({blen, raw});
	endtask

	function automatic logic [15:0] pick_raw();
		case ($urandom_range(0, 11))
			0: return 16'h0000;
			1: return 16'hFFFF;
			2: return 16'h8000;
			3: return 16'h7FFF;
			4: return 16'h0080;
			5: return 16'hFF7F;
			default: return 16'($urandom_range(0, 65535));
		endcase
	endfunction

	task automatic write_reg(input logic [CfgIndexW-1:0] idx, input logic [StepW-1:0] value);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		do
			@(posedge clk);
		while (!cfg_ready);
		cfg_valid <= 1'b0;
		if (idx == RegPhaseStep)
			step_reg = value;
		else
			byte_mode = value[0];
		@(negedge clk);
	endtask

	task automatic set_idling(input idle_mode_t mode);
		case (mode)
			IDLE_NONE: begin
				send_idle_pct = 0;
				recv_stall_pct = 0;
			end
			IDLE_SEND: begin
				send_idle_pct = 85;
				recv_stall_pct = 0;
			end
			IDLE_RECV: begin
				send_idle_pct = 0;
				recv_stall_pct = 85;
			end
			IDLE_BOTH: begin
				send_idle_pct = 17;
				recv_stall_pct = 17;
			end
		endcase
	endtask

	task automatic wait_drained();
		while (pending_words.size() != 0 || s_tvalid || expected_samples.size() != 0)
			@(negedge clk);
		repeat (SettleCycles) @(negedge clk);
	endtask

	task automatic add_random_items(input int budget);
		int added;
		int kind;
		int len;
		int long_pct;
		added = 0;
		long_pct = (step_reg > 21'd262144) ? 40 : 0;
		while (added < budget) begin
			kind = $urandom_range(0, 99);
			if (kind < 80) begin
				if ($urandom_range(0, 99) < long_pct)
					len = $urandom_range(13, 40);
				else
					len = $urandom_range(1, 8);
				for (int i = 0; i < len; i++)
					push_word(pick_raw(), 16'(len));
				added += len;
			end else if (kind < 87) begin
				push_word(pick_raw(), 16'd0);
				added++;
			end else if (kind < 94) begin
				len = $urandom_range(2, 8);
				for (int i = 0; i < len / 2; i++)
					push_word(pick_raw(), 16'(len));
				push_word(pick_raw(), 16'($urandom_range(1, 65535)));
				added += len / 2 + 1;
			end else begin
				push_word(pick_raw(), 16'($urandom_range(1, 65535)));
				added++;
			end
		end
	endtask

	task automatic run_phase(input logic [StepW-1:0] step, input logic bmode,
			input idle_mode_t mode, input bit hold, input bit pause);
		write_reg(RegPhaseStep, step);
		write_reg(RegByteSamples, StepW'(bmode));
		set_idling(mode);
		if (hold)
			hold_requests++;
		if (pause) begin
			add_random_items(PhaseItems / 2);
			wait_drained();
			add_random_items(PhaseItems / 2);
		end else begin
			add_random_items(PhaseItems);
		end
		wait_drained();
	endtask

	initial begin
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		set_idling(IDLE_NONE);
		push_word(16'h7FFF, 16'd1);
		push_word(16'h8000, 16'd0);
		push_word(16'h8000, 16'd4);
		push_word(16'h7FFF, 16'd4);
		push_word(16'h0000, 16'd4);
		push_word(16'hFFFF, 16'd4);
		push_word(16'hFFFF, 16'hFFFF);
		push_word(16'h1234, 16'd2);
		push_word(16'h4000, 16'd5);
		push_word(16'hC000, 16'd5);
		push_word(16'h2000, 16'd3);
		wait_drained();

		write_reg(RegPhaseStep, 21'd4096);
		write_reg(RegByteSamples, 21'd1);
		push_word(16'h0000, 16'd3);
		push_word(16'hABFF, 16'd3);
		push_word(16'h5480, 16'd3);
		wait_drained();

		write_reg(RegPhaseStep, 21'd1);
		write_reg(RegByteSamples, 21'd0);
		push_word(16'h0001, 16'd2);
		push_word(16'hFFFE, 16'd2);
		wait_drained();

		write_reg(RegPhaseStep, 21'h1FFFFF);
		push_word(16'h5555, 16'd1);
		wait_drained();

		run_phase(21'd65536, 1'b0, IDLE_NONE, 1'b0, 1'b0);
		run_phase(21'd4096, 1'b1, IDLE_SEND, 1'b0, 1'b0);
		run_phase(21'd8192, 1'b0, IDLE_NONE, 1'b1, 1'b0);
		run_phase(21'd1048576, 1'b0, IDLE_RECV, 1'b0, 1'b0);
		run_phase(StepW'($urandom_range(4096, 1048576)), 1'($urandom_range(0, 1)),
			IDLE_BOTH, 1'b0, 1'b1);
		run_phase(21'h1FFFFF, 1'b1, IDLE_RECV, 1'b0, 1'b0);
		run_phase(21'd0, 1'b0, IDLE_BOTH, 1'b0, 1'b0);
		run_phase(21'd23170, 1'b1, IDLE_NONE, 1'b0, 1'b0);

		if (err_count == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
